@@ design/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the SHA-1 suffix search block.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MaxSuffix    = 8;
  localparam int AlphabetSize = 10;
  localparam int PrefixBytes  = 64;
  localparam int NumCfgRegs   = 8;
  localparam int CfgWidth     = 64;
  localparam int CfgIdxWidth  = 4;
  localparam int LenWidth     = 4;
  localparam int DigitWidth   = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] CharBase = 8'h61;

  typedef struct packed {
    logic [0:0]  restart;
    logic [3:0]  suffix_length;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] digest_word_a;
    logic [31:0] digest_word_b;
    logic [31:0] digest_word_c;
    logic [31:0] digest_word_d;
    logic [31:0] digest_word_e;
    logic        last;
    logic        exhausted;
    logic [31:0] tested_count;
  } out_item_t;

  // Round constant by round index
  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

endpackage

@@ design/sss_if.sv @@
// ----------------------------------------------------------------------------
// sss_in_if / sss_out_if
// Valid/ready channels for the suffix search items.
// ----------------------------------------------------------------------------
interface sss_in_if;
  logic                valid;
  logic                ready;
  sss_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sss_out_if;
  logic                valid;
  logic                ready;
  sss_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/sha1_suffix_search.sv @@
// ----------------------------------------------------------------------------
// sha1_suffix_search
// Proof-of-work search: hashes prefix + odometer suffix + 0x00 with SHA-1.
// ----------------------------------------------------------------------------
// Channel   Dir  Item
// in        in   restart, suffix_length
// res       out  found, digest words a..e, last, exhausted, tested_count
// cfg       in   wr_en, wr_index, wr_data (prefix registers)
//
// A hashing step runs two SHA-1 blocks in turn on the single shared round unit,
// each through S_LOAD, the S_ROUND rounds and S_FIN; the result is registered
// in S_FIN of the second block, and the block then returns to S_IDLE.
// Restart and exhausted items give their result in the cycle after acceptance.
// rst is synchronous; the block takes no item while busy or while the result
// register is still full. The message schedule is a 16-word shift window.
module sha1_suffix_search #(
  parameter int ALPHABET_SIZE = sss_pkg::AlphabetSize
) (
  input  logic                              clk,
  input  logic                              rst,
  sss_in_if.sink                            in,
  sss_out_if.source                         res,
  input  logic                              wr_en,
  input  logic [sss_pkg::CfgIdxWidth-1:0]   wr_index,
  input  logic [sss_pkg::CfgWidth-1:0]      wr_data
);

  localparam int MAX_SUFFIX = sss_pkg::MaxSuffix;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOAD  = 4'b0010,
    S_ROUND = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state;
  logic [sss_pkg::CfgWidth-1:0] prefix [sss_pkg::NumCfgRegs];
  logic [sss_pkg::DigitWidth-1:0] digits [MAX_SUFFIX];
  logic [sss_pkg::LenWidth-1:0] active_length;
  logic        run_finished;
  logic [31:0] hash_count;
  logic        blk;              // 0 first block, 1 second
  logic [6:0]  rnd;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic        is_last;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sss_pkg::NumCfgRegs; i++) prefix[i] <= '0;
    end else if (wr_en && wr_index < sss_pkg::CfgIdxWidth'(sss_pkg::NumCfgRegs)) begin
      prefix[wr_index[2:0]] <= wr_data;
    end
  end

  // Message byte at position p of the second 64-byte block of the 128-byte padded message
  function automatic logic [7:0] msg2_byte(input logic [5:0] p,
      input logic [sss_pkg::LenWidth-1:0] len,
      input logic [sss_pkg::DigitWidth-1:0] dg [MAX_SUFFIX]);
    logic [7:0]  v;
    logic [10:0] bits;
    bits = 11'((sss_pkg::PrefixBytes + 32'(len) + 1) * 8);
    v = 8'h00;
    if (32'(p) < 32'(len)) v = sss_pkg::CharBase + 8'(dg[p[2:0]]);
    else if (32'(p) == 32'(len) + 1) v = 8'h80;
    else if (p == 6'd62) v = {5'b0, bits[10:8]};
    else if (p == 6'd63) v = bits[7:0];
    return v;
  endfunction

  // Last suffix detection
  always_comb begin
    is_last = 1'b1;
    for (int i = 0; i < MAX_SUFFIX; i++)
      if (32'(i) < 32'(active_length) && 32'(digits[i]) != ALPHABET_SIZE - 1)
        is_last = 1'b0;
  end

  // Shared round unit
  logic [31:0] wnew, wcur, t_sum;
  assign wnew  = {w[13] ^ w[8] ^ w[2] ^ w[0]} << 1 | (w[13] ^ w[8] ^ w[2] ^ w[0]) >> 31;
  assign wcur  = (rnd < 7'd16) ? w[0] : wnew;
  assign t_sum = {a[26:0], a[31:27]} + sss_pkg::round_f(rnd, b, c, d) + e
                 + sss_pkg::round_k(rnd) + wcur;

  logic in_acc;
  assign in.ready = (state == S_IDLE) && !res.valid;
  assign in_acc   = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res.valid     <= 1'b0;
      active_length <= '0;
      run_finished  <= 1'b1;
      hash_count    <= '0;
      for (int i = 0; i < MAX_SUFFIX; i++) digits[i] <= '0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in.data.restart[0]) begin
              active_length <= (32'(in.data.suffix_length) > MAX_SUFFIX)
                             ? sss_pkg::LenWidth'(MAX_SUFFIX) : in.data.suffix_length;
              for (int i = 0; i < MAX_SUFFIX; i++) digits[i] <= '0;
              hash_count   <= '0;
              run_finished <= 1'b0;
              res.data     <= '0;
              res.valid    <= 1'b1;
            end else if (run_finished) begin
              res.data.found         <= 1'b0;
              res.data.digest_word_a <= '0;
              res.data.digest_word_b <= '0;
              res.data.digest_word_c <= '0;
              res.data.digest_word_d <= '0;
              res.data.digest_word_e <= '0;
              res.data.last          <= 1'b0;
              res.data.exhausted     <= 1'b1;
              res.data.tested_count  <= hash_count;
              res.valid              <= 1'b1;
            end else begin
              blk   <= 1'b0;
              h[0] <= sss_pkg::H0; h[1] <= sss_pkg::H1; h[2] <= sss_pkg::H2;
              h[3] <= sss_pkg::H3; h[4] <= sss_pkg::H4;
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          // fill schedule window and working vars for the current block
          for (int i = 0; i < 16; i++) begin
            if (!blk) w[i] <= prefix[i/2][63-32*(i%2) -: 32];
            else w[i] <= {msg2_byte(6'(4*i), active_length, digits),
                          msg2_byte(6'(4*i+1), active_length, digits),
                          msg2_byte(6'(4*i+2), active_length, digits),
                          msg2_byte(6'(4*i+3), active_length, digits)};
          end
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wcur;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t_sum;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= S_FIN;
        end
        S_FIN: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (!blk) begin
            blk   <= 1'b1;
            state <= S_LOAD;
          end else begin
            res.data.found         <= (h[0] + a) == 32'd0;
            res.data.digest_word_a <= h[0] + a;
            res.data.digest_word_b <= h[1] + b;
            res.data.digest_word_c <= h[2] + c;
            res.data.digest_word_d <= h[3] + d;
            res.data.digest_word_e <= h[4] + e;
            res.data.last          <= is_last;
            res.data.exhausted     <= 1'b0;
            res.data.tested_count  <= (hash_count == '1) ? hash_count : hash_count + 32'd1;
            if (hash_count != '1) hash_count <= hash_count + 32'd1;
            res.valid <= 1'b1;
            if (is_last) run_finished <= 1'b1;
            else begin
              // ripple increment, least significant is highest active index
              logic carry;
              carry = 1'b1;
              for (int i = MAX_SUFFIX - 1; i >= 0; i--) begin
                if (32'(i) < 32'(active_length) && carry) begin
                  if (32'(digits[i]) + 1 < ALPHABET_SIZE) begin
                    digits[i] <= digits[i] + 1'b1;
                    carry = 1'b0;
                  end else digits[i] <= '0;
                end
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in.ready) else $error("ready while hashing");
  a_round_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 7'd79) |=> state == S_FIN) else $error("round count");
  a_found_digest: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.found |-> res.data.digest_word_a == 32'd0)
    else $error("found without zero word");
  a_exh_no_hash: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.exhausted |-> !res.data.found && !res.data.last)
    else $error("exhausted with hash flags");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sha1_suffix_search. Restart and step items are
// queued per phase, driven on a valid/ready channel with random gaps, and
// every result is compared field by field with a SHA-1 search predictor.
// The prefix registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int WatchLimit = 20000;
  localparam int HoldStart  = 6000;
  localparam int HoldLen    = 2500;

  logic clk;
  logic rst;
  logic wr_en;
  logic [sss_pkg::CfgIdxWidth-1:0] wr_index;
  logic [sss_pkg::CfgWidth-1:0]    wr_data;

  sss_in_if  in_ch();
  sss_out_if res_ch();

  sha1_suffix_search DUT (
    .clk(clk), .rst(rst), .in(in_ch), .res(res_ch),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Predictor copy of the prefix and search state
  logic [63:0]                    prefix_copy [sss_pkg::NumCfgRegs];
  logic [sss_pkg::DigitWidth-1:0] digits [sss_pkg::MaxSuffix];
  int unsigned                    act_len;
  bit                             run_done;
  logic [31:0]                    hashes;

  sss_pkg::in_item_t  pending_items [$];
  sss_pkg::out_item_t expected_results [$];

  int  errors, n_hashed, n_last, n_exhausted, n_restart, n_checked;
  bit  burst_mode;
  int  send_gap, take_gap, idle_cycles, cycle_no;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
  endtask

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One SHA-1 compression over a 512-bit block
  function automatic logic [159:0] sha1_compress(input logic [159:0] hin,
                                                 input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = hin;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c, hin[63:32] + d, hin[31:0] + e};
  endfunction

  // Hash of prefix, current suffix and a trailing zero byte
  function automatic logic [159:0] hash_suffix();
    logic [1023:0] msg;
    int unsigned   len;
    logic [159:0]  h;
    msg = '0;
    for (int i = 0; i < sss_pkg::PrefixBytes; i++)
      msg[1023 - 8*i -: 8] = prefix_copy[i / 8][63 - 8*(i % 8) -: 8];
    for (int i = 0; i < act_len; i++)
      msg[1023 - 8*(sss_pkg::PrefixBytes + i) -: 8] = sss_pkg::CharBase + digits[i];
    len = sss_pkg::PrefixBytes + act_len + 1;
    msg[1023 - 8*len -: 8] = 8'h80;
    msg[63:0] = 64'(len) * 8;
    h = sha1_compress({sss_pkg::H0, sss_pkg::H1, sss_pkg::H2, sss_pkg::H3, sss_pkg::H4},
                      msg[1023:512]);
    return sha1_compress(h, msg[511:0]);
  endfunction

  // Advance the search state by one item and queue the expected result
  task automatic predict_search(input sss_pkg::in_item_t it);
    sss_pkg::out_item_t r;
    logic [159:0] h;
    bit          at_end;
    int          i;
    r = '0;
    if (it.restart) begin
      act_len = (it.suffix_length > sss_pkg::MaxSuffix) ? sss_pkg::MaxSuffix : it.suffix_length;
      foreach (digits[j]) digits[j] = '0;
      hashes = '0;
      run_done = 1'b0;
      n_restart++;
    end else if (run_done) begin
      r.exhausted = 1'b1;
      r.tested_count = hashes;
      n_exhausted++;
    end else begin
      h = hash_suffix();
      if (hashes != 32'hFFFFFFFF) hashes++;
      at_end = 1'b1;
      for (i = 0; i < act_len; i++)
        if (digits[i] != sss_pkg::AlphabetSize - 1) at_end = 1'b0;
      {r.digest_word_a, r.digest_word_b, r.digest_word_c, r.digest_word_d,
       r.digest_word_e} = h;
      r.found = (h[159:128] == 32'd0);
      r.last = at_end;
      r.tested_count = hashes;
      n_hashed++;
      if (at_end) begin
        run_done = 1'b1;
        n_last++;
      end else begin
        i = act_len;
        while (i > 0) begin
          i--;
          if (digits[i] + 1 < sss_pkg::AlphabetSize) begin
            digits[i]++;
            break;
          end
          digits[i] = '0;
        end
      end
    end
    expected_results.push_back(r);
  endtask

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, 19);
  endfunction

  // Driver: the front of the pending queue is the item on offer
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_search(pending_items.pop_front());
        send_gap = draw_gap();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results, with random stalls and one long hold-off
  always @(posedge clk) begin
    sss_pkg::out_item_t w;
    if (rst) begin
      res_ch.ready <= 1'b0;
      take_gap = 0;
      cycle_no = 0;
    end else begin
      cycle_no++;
      if (res_ch.valid && res_ch.ready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("unexpected result at %0t", $time);
        end else begin
          w = expected_results.pop_front();
          if (res_ch.data.found !== w.found)
            report("found", 32'(res_ch.data.found), 32'(w.found));
          if (res_ch.data.digest_word_a !== w.digest_word_a)
            report("digest_word_a", res_ch.data.digest_word_a, w.digest_word_a);
          if (res_ch.data.digest_word_b !== w.digest_word_b)
            report("digest_word_b", res_ch.data.digest_word_b, w.digest_word_b);
          if (res_ch.data.digest_word_c !== w.digest_word_c)
            report("digest_word_c", res_ch.data.digest_word_c, w.digest_word_c);
          if (res_ch.data.digest_word_d !== w.digest_word_d)
            report("digest_word_d", res_ch.data.digest_word_d, w.digest_word_d);
          if (res_ch.data.digest_word_e !== w.digest_word_e)
            report("digest_word_e", res_ch.data.digest_word_e, w.digest_word_e);
          if (res_ch.data.last !== w.last)
            report("last", 32'(res_ch.data.last), 32'(w.last));
          if (res_ch.data.exhausted !== w.exhausted)
            report("exhausted", 32'(res_ch.data.exhausted), 32'(w.exhausted));
          if (res_ch.data.tested_count !== w.tested_count)
            report("tested_count", res_ch.data.tested_count, w.tested_count);
        end
        take_gap = draw_gap();
      end
      if (cycle_no >= HoldStart && cycle_no < HoldStart + HoldLen) begin
        res_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("timeout: no progress for %0d cycles", WatchLimit);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_prefix(input int idx, input logic [63:0] v);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx[sss_pkg::CfgIdxWidth-1:0];
    wr_data  <= v;
    if (idx < sss_pkg::NumCfgRegs) prefix_copy[idx] = v;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic queue_item(input bit rs, input int len);
    sss_pkg::in_item_t it;
    it.restart = rs;
    it.suffix_length = len[3:0];
    pending_items.push_back(it);
  endtask

  // Restart then walk the run, sometimes past its end, and sometimes after a stray step
  task automatic queue_random_runs(input int n_items);
    int budget, len, steps;
    budget = n_items;
    while (budget > 0) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(3, 15);
        1, 2, 3: len = 0;
        4, 5, 6: len = 1;
        default: len = 2;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        queue_item(1'b0, $urandom_range(0, 15));
        budget--;
      end
      queue_item(1'b1, len);
      if (len == 0) steps = $urandom_range(1, 4);
      else if (len == 1) steps = $urandom_range(1, 14);
      else if (len == 2) steps = $urandom_range(1, 104);
      else steps = $urandom_range(1, 8);
      for (int i = 0; i < steps; i++) queue_item(1'b0, $urandom_range(0, 15));
      budget -= steps + 1;
    end
  endtask

  task automatic run_phase(input int n_items);
    burst_mode = ($urandom_range(0, 3) == 0);
    queue_random_runs(n_items);
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [63:0] v;
    errors = 0; n_hashed = 0; n_last = 0; n_exhausted = 0; n_restart = 0; n_checked = 0;
    foreach (prefix_copy[i]) prefix_copy[i] = '0;
    foreach (digits[i]) digits[i] = '0;
    act_len = 0; run_done = 1'b1; hashes = '0; burst_mode = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: prefix at its reset value of zero
    queue_item(1'b0, 5);          // step before any restart
    queue_item(1'b1, 0);          // empty suffix: one hash, flagged last
    queue_item(1'b0, 15);
    queue_item(1'b0, 0);          // run over
    queue_item(1'b1, 15);         // overlong length saturates
    queue_item(1'b0, 7);
    queue_item(1'b0, 0);
    queue_item(1'b1, 8);
    queue_item(1'b0, 9);
    queue_item(1'b1, 1);
    for (int i = 0; i < 11; i++) queue_item(1'b0, i);
    queue_item(1'b1, 9);
    queue_item(1'b0, 0);
    run_phase(300);

    // All ones, with writes to unused indexes that must be ignored
    for (int i = 0; i < 16; i++)
      write_prefix(i, i < sss_pkg::NumCfgRegs ? '1 : 64'h0123456789ABCDEF);
    repeat (5) @(posedge clk);
    run_phase(380);

    // Random prefix
    for (int i = 0; i < sss_pkg::NumCfgRegs; i++) write_prefix(i, {$urandom, $urandom});
    run_phase(380);

    // Random prefix with plenty of zero bytes
    for (int i = 0; i < sss_pkg::NumCfgRegs; i++) begin
      v = {$urandom, $urandom};
      for (int b = 0; b < 8; b++)
        if ($urandom_range(0, 2) == 0) v[8*b +: 8] = 8'h00;
      write_prefix(i, v);
    end
    run_phase(380);

    // Back to all zero by explicit writes
    for (int i = 0; i < sss_pkg::NumCfgRegs; i++) write_prefix(i, '0);
    run_phase(380);

    repeat (200) @(posedge clk);
    $display("covered %0d restarts, %0d hashes (%0d last), %0d exhausted steps",
             n_restart, n_hashed, n_last, n_exhausted);
    $display("%0d results checked over five prefix settings, %0d mismatches",
             n_checked, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
